// ----- hdl/tdof_pkg.sv -----
`timescale 1ns / 1ps
// Types and fixed constants for the tie-point deviation outlier filter.
// No dependencies; imported by tiepoint_deviation_outlier_filter.
package tdof_pkg;

    localparam int RATIO_W   = 23;
    localparam int DIV_STEPS = 23;
    localparam int CFG_W     = 16;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [RATIO_W-1:0] RATIO_SAT = {RATIO_W{1'b1}};
    localparam logic [RATIO_W-1:0] MIN_RESET = 23'd2559744;   // 9999.0 in Q15.8

    localparam logic [CFG_W-1:0] CORR_FLOOR_RST   = 16'd327;
    localparam logic [CFG_W-1:0] SPREAD_FRAC_RST  = 16'd19661;
    localparam logic [CFG_W-1:0] THR_FLOOR_RST    = 16'd256;

    localparam logic [1:0] REG_CORR_FLOOR  = 2'd0;
    localparam logic [1:0] REG_SPREAD_FRAC = 2'd1;
    localparam logic [1:0] REG_THR_FLOOR   = 2'd2;

    typedef struct packed {
        logic [15:0] correlation_q;
        logic [15:0] deviation_q;
        logic        last_point;
    } t_point;

    typedef struct packed {
        logic [5:0] point_index;
        logic       kept_valid;
        logic       run_end;
        logic [6:0] kept_total;
        logic       set_changed;
    } t_result;

endpackage

// ----- hdl/tiepoint_deviation_outlier_filter.sv -----
`timescale 1ns / 1ps
// Tie-point deviation outlier filter, top level.
// Depends on tdof_pkg for payload types, register codes and constants.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one tie point
//   per transfer. Each point is a correlation (Q1.15), a deviation (Q8.8)
//   and a last_point flag. o_in_ready is high only while the sequencer idles.
//   A qualifying point runs a radix-2 restoring divider for its Q15.8 ratio
//   (accept, 23 divider steps and a store); a non-qualifying or saturating
//   point goes straight to the store, and a dropped point is not stored.
//   After the last point the threshold is formed (multiply, then add), one scan
//   over the loaded points counts kept points, then a second emits them, both
//   scans bound by the single registered read port of the ratio memory.
//   Output channel (o_out_valid / i_out_ready / o_out_data) carries one
//   transfer per kept point, or one with kept_valid low when none is kept.
//   A stalled receiver holds the output register and pauses the emit scan.
//   Reset clears the registers to defaults and starts an empty run; the
//   ratio memory needs no clearing. APB writes are meant for idle periods.
module tiepoint_deviation_outlier_filter
    import tdof_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_point             i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_result            o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int SW = 5;
    localparam int PW = RATIO_W + CFG_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DIV       = 4'd1;
    localparam logic [3:0] S_STORE     = 4'd2;
    localparam logic [3:0] S_THR_MUL   = 4'd3;
    localparam logic [3:0] S_THR_ADD   = 4'd4;
    localparam logic [3:0] S_CNT_RD    = 4'd5;
    localparam logic [3:0] S_CNT_CHK   = 4'd6;
    localparam logic [3:0] S_CNT_END   = 4'd7;
    localparam logic [3:0] S_EMIT_NONE = 4'd8;
    localparam logic [3:0] S_EMIT_RD   = 4'd9;
    localparam logic [3:0] S_EMIT_CHK  = 4'd10;
    localparam logic [3:0] S_CLEAR     = 4'd11;

    logic [CFG_W-1:0]   r_corr_floor;
    logic [CFG_W-1:0]   r_spread_frac;
    logic [CFG_W-1:0]   r_thr_floor;

    logic [3:0]         r_state;
    logic               r_q;
    logic               r_last;
    logic [15:0]        r_div;
    logic [15:0]        r_rem;
    logic [DIV_STEPS-1:0] r_dbits;
    logic [RATIO_W-1:0] r_quo;
    logic [SW-1:0]      r_step;
    logic [RATIO_W-1:0] r_min;
    logic [RATIO_W-1:0] r_max;
    logic [CW-1:0]      r_loaded;
    logic [PW-1:0]      r_prod;
    logic [RATIO_W:0]   r_thr;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_k;
    logic               r_changed;
    logic               r_out_valid;
    t_result            r_out;

    logic [RATIO_W:0]   r_mem [MAX_POINTS];
    logic [RATIO_W:0]   r_rd_data;

    logic               cfg_wr;
    logic               in_xfer;
    logic               slot_free;
    logic               out_load;
    t_result            n_out;
    logic               acc_q;
    logic               acc_sat;
    logic [16:0]        trial;
    logic               trial_ge;
    logic               rd_kept;
    logic [RATIO_W-1:0] spread;
    logic [RATIO_W:0]   thr_sum;

    assign pready      = 1'b1;
    assign cfg_wr      = psel & penable & pwrite;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid & o_in_ready;
    assign slot_free   = ~r_out_valid | i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign acc_q    = i_in_data.correlation_q > r_corr_floor;
    assign acc_sat  = {8'd0, i_in_data.deviation_q} >= {i_in_data.correlation_q, 8'd0};
    assign trial    = {r_rem, r_dbits[DIV_STEPS-1]};
    assign trial_ge = trial >= {1'b0, r_div};
    assign rd_kept  = r_rd_data[RATIO_W] & ({1'b0, r_rd_data[RATIO_W-1:0]} <= r_thr);
    assign spread   = r_max - r_min;
    assign thr_sum  = {1'b0, r_min} + {1'b0, r_prod[PW-1:CFG_W]};

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_CORR_FLOOR:  prdata = {{(PDATA_W-CFG_W){1'b0}}, r_corr_floor};
            REG_SPREAD_FRAC: prdata = {{(PDATA_W-CFG_W){1'b0}}, r_spread_frac};
            REG_THR_FLOOR:   prdata = {{(PDATA_W-CFG_W){1'b0}}, r_thr_floor};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corr_floor  <= CORR_FLOOR_RST;
            r_spread_frac <= SPREAD_FRAC_RST;
            r_thr_floor   <= THR_FLOOR_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_CORR_FLOOR:  r_corr_floor  <= pwdata[CFG_W-1:0];
                REG_SPREAD_FRAC: r_spread_frac <= pwdata[CFG_W-1:0];
                REG_THR_FLOOR:   r_thr_floor   <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // ratio memory: write in the store state, registered read at scan index
    always_ff @(posedge i_clk) begin
        if (r_state == S_STORE)
            r_mem[r_loaded[AW-1:0]] <= {r_q, r_quo};
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    always_comb begin
        out_load = 1'b0;
        n_out    = '0;
        if (r_state == S_EMIT_NONE && slot_free) begin
            out_load          = 1'b1;
            n_out.run_end     = 1'b1;
            n_out.set_changed = r_changed;
        end else if (r_state == S_EMIT_CHK && rd_kept && slot_free) begin
            out_load          = 1'b1;
            n_out.point_index = 6'(r_idx);
            n_out.kept_valid  = 1'b1;
            n_out.run_end     = (r_k + 1'b1) == r_n;
            n_out.kept_total  = 7'(r_n);
            n_out.set_changed = r_changed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load)
            r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_min    <= MIN_RESET;
            r_max    <= '0;
            r_loaded <= '0;
            r_idx    <= '0;
            r_n      <= '0;
            r_k      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_q    <= acc_q;
                        r_last <= i_in_data.last_point;
                        r_div  <= i_in_data.correlation_q;
                        r_rem  <= {8'd0, i_in_data.deviation_q[15:8]};
                        r_dbits <= {i_in_data.deviation_q[7:0], 15'd0};
                        r_step <= SW'(DIV_STEPS - 1);
                        if (r_loaded >= CW'(MAX_POINTS)) begin
                            if (i_in_data.last_point)
                                r_state <= S_THR_MUL;
                        end else if (!acc_q) begin
                            r_quo   <= '0;
                            r_state <= S_STORE;
                        end else if (acc_sat) begin
                            r_quo   <= RATIO_SAT;
                            r_state <= S_STORE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem   <= trial_ge ? 16'(trial - {1'b0, r_div}) : trial[15:0];
                    r_quo   <= {r_quo[RATIO_W-2:0], trial_ge};
                    r_dbits <= {r_dbits[DIV_STEPS-2:0], 1'b0};
                    r_step  <= r_step - 1'b1;
                    if (r_step == '0)
                        r_state <= S_STORE;
                end
                S_STORE: begin
                    if (r_q) begin
                        if (r_quo < r_min)
                            r_min <= r_quo;
                        if (r_quo > r_max)
                            r_max <= r_quo;
                    end
                    r_loaded <= r_loaded + 1'b1;
                    r_state  <= r_last ? S_THR_MUL : S_IDLE;
                end
                S_THR_MUL: begin
                    r_prod  <= PW'(spread * r_spread_frac);
                    r_state <= S_THR_ADD;
                end
                S_THR_ADD: begin
                    // spread is only meaningful with a qualifying point
                    r_thr   <= (thr_sum <= {8'd0, r_thr_floor}) ?
                               {8'd0, r_thr_floor} : thr_sum;
                    r_idx   <= '0;
                    r_n     <= '0;
                    r_state <= S_CNT_RD;
                end
                S_CNT_RD: begin
                    r_state <= (r_idx == r_loaded) ? S_CNT_END : S_CNT_CHK;
                end
                S_CNT_CHK: begin
                    if (rd_kept)
                        r_n <= r_n + 1'b1;
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_CNT_RD;
                end
                S_CNT_END: begin
                    r_changed <= r_n != r_loaded;
                    r_idx     <= '0;
                    r_k       <= '0;
                    r_state   <= (r_n == '0) ? S_EMIT_NONE : S_EMIT_RD;
                end
                S_EMIT_NONE: begin
                    if (slot_free)
                        r_state <= S_CLEAR;
                end
                S_EMIT_RD: begin
                    r_state <= (r_idx == r_loaded) ? S_CLEAR : S_EMIT_CHK;
                end
                S_EMIT_CHK: begin
                    if (!rd_kept) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_EMIT_RD;
                    end else if (slot_free) begin
                        r_k     <= r_k + 1'b1;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_EMIT_RD;
                    end
                end
                S_CLEAR: begin
                    r_min    <= MIN_RESET;
                    r_max    <= '0;
                    r_loaded <= '0;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- tb/tb_tiepoint_deviation_outlier_filter.sv -----
`timescale 1ns / 1ps
// Testbench for tiepoint_deviation_outlier_filter: sends tie-point runs and APB settings,
// predicts the kept-point transfers with a local model and checks each one.
// Depends on tdof_pkg and the filter RTL; needs no files or arguments.
module tb_tiepoint_deviation_outlier_filter;
    import tdof_pkg::*;

    localparam int NPTS          = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int END_CYCLES    = 200;
    localparam int STALL_LIMIT   = 4000;
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = 4'd12;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    t_point             in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_result            out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // local model of the filter
    logic [CFG_W-1:0]   cfg_corr_floor = CORR_FLOOR_RST;
    logic [CFG_W-1:0]   cfg_spread     = SPREAD_FRAC_RST;
    logic [CFG_W-1:0]   cfg_thr_floor  = THR_FLOOR_RST;
    logic [RATIO_W-1:0] ratio_mem [NPTS];
    logic               qual_mem [NPTS];
    logic [RATIO_W-1:0] min_ratio = MIN_RESET;
    logic [RATIO_W-1:0] max_ratio = '0;
    int unsigned        loaded_n = 0;
    t_result            kept_queue [$];

    int fail_count = 0;
    int points_sent = 0;
    int runs_done = 0;
    int results_checked = 0;
    int reg_writes = 0;
    int burst_left = 0;
    int quiet_cycles = 0;

    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   rx_mode = 0;
    int   rx_mode_left = 0;

    tiepoint_deviation_outlier_filter #(
        .MAX_POINTS(NPTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // load one point into the model; on the last point, queue the kept-point transfers
    task automatic filter_point(input t_point p);
        logic [RATIO_W-1:0] r;
        logic               q;
        longint             quot;
        longint             thr;
        int unsigned        n;
        int unsigned        k;
        logic               changed;
        t_result            res;
        if (loaded_n < NPTS) begin
            q = p.correlation_q > cfg_corr_floor;
            r = '0;
            if (q && p.correlation_q != 0) begin
                quot = (longint'(p.deviation_q) << 15) / longint'(p.correlation_q);
                r = (quot > longint'(RATIO_SAT)) ? RATIO_SAT : quot[RATIO_W-1:0];
                if (r < min_ratio) min_ratio = r;
                if (r > max_ratio) max_ratio = r;
            end
            ratio_mem[loaded_n] = r;
            qual_mem[loaded_n] = q;
            loaded_n++;
        end
        if (!p.last_point) return;

        if (max_ratio >= min_ratio)
            thr = longint'(min_ratio)
                + ((longint'(max_ratio - min_ratio) * longint'(cfg_spread)) >>> 16);
        else
            thr = longint'(min_ratio)
                - ((longint'(min_ratio - max_ratio) * longint'(cfg_spread) + 65535) >>> 16);
        if (thr <= longint'(cfg_thr_floor)) thr = longint'(cfg_thr_floor);

        n = 0;
        for (int i = 0; i < loaded_n; i++)
            if (qual_mem[i] && longint'(ratio_mem[i]) <= thr) n++;
        changed = n != loaded_n;

        if (n == 0) begin
            res.point_index = '0;
            res.kept_valid  = 1'b0;
            res.run_end     = 1'b1;
            res.kept_total  = '0;
            res.set_changed = changed;
            kept_queue.push_back(res);
        end else begin
            k = 0;
            for (int i = 0; i < loaded_n; i++) begin
                if (qual_mem[i] && longint'(ratio_mem[i]) <= thr) begin
                    res.point_index = 6'(i);
                    res.kept_valid  = 1'b1;
                    res.run_end     = (k + 1 == n);
                    res.kept_total  = n[6:0];
                    res.set_changed = changed;
                    kept_queue.push_back(res);
                    k++;
                end
            end
        end
        min_ratio = MIN_RESET;
        max_ratio = '0;
        loaded_n = 0;
        runs_done++;
    endtask

    // one point transfer; valid stays high within a burst, so its points need no gap
    task automatic send_point(input logic [15:0] corr, input logic [15:0] dev,
                              input logic last);
        int gap;
        t_point p;
        p.correlation_q = corr;
        p.deviation_q   = dev;
        p.last_point    = last;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= p;
        do @(posedge i_clk); while (!in_ready);
        filter_point(p);
        points_sent++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (kept_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_writes++;
        if (addr[1:0] == 2'b00) begin
            case (addr[3:2])
                REG_CORR_FLOOR:  cfg_corr_floor = data[CFG_W-1:0];
                REG_SPREAD_FRAC: cfg_spread     = data[CFG_W-1:0];
                REG_THR_FLOOR:   cfg_thr_floor  = data[CFG_W-1:0];
                default: ;
            endcase
        end
    endtask

    task automatic apb_check(input logic [1:0] idx, input logic [CFG_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[CFG_W-1:0] !== want) begin
            $error("register %0d: expected %0d, got %0d", idx, want, prdata[CFG_W-1:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write all three registers with junk in the upper half, then read them back
    task automatic apply_settings(input logic [15:0] corr_floor, input logic [15:0] spread,
                                  input logic [15:0] thr_floor);
        apb_write({REG_CORR_FLOOR, 2'b00},  {16'($urandom), corr_floor});
        apb_write({REG_SPREAD_FRAC, 2'b00}, {16'($urandom), spread});
        apb_write({REG_THR_FLOOR, 2'b00},   {16'($urandom), thr_floor});
        apb_check(REG_CORR_FLOOR,  cfg_corr_floor);
        apb_check(REG_SPREAD_FRAC, cfg_spread);
        apb_check(REG_THR_FLOOR,   cfg_thr_floor);
    endtask

    function automatic logic [15:0] pick_correlation();
        int unsigned sel;
        int unsigned lo;
        int unsigned fl;
        sel = $urandom_range(0, 9);
        fl = (cfg_corr_floor > 32768) ? 32768 : cfg_corr_floor;
        lo = (fl >= 32768) ? 32768 : fl + 1;
        if (sel <= 6) return 16'($urandom_range(lo, 32768));
        if (sel == 7) return 16'($urandom_range(0, fl));
        if (sel == 8) begin
            case ($urandom_range(0, 3))
                0: return 16'd0;
                1: return 16'd32768;
                2: return 16'(fl);
                default: return 16'(lo);
            endcase
        end
        return 16'($urandom_range(0, 32768));
    endfunction

    function automatic logic [15:0] pick_deviation();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5) return 16'($urandom_range(0, 65535));
        if (sel <= 7) return 16'($urandom_range(0, 511));
        if (sel == 8) return 16'd0;
        return 16'hFFFF;
    endfunction

    task automatic send_run(input int len);
        for (int i = 0; i < len; i++)
            send_point(pick_correlation(), pick_deviation(), i == len - 1);
    endtask

    task automatic random_runs(input int budget, input bit with_overflow);
        int sent;
        int sel;
        int len;
        sent = 0;
        if (with_overflow) begin
            send_run(NPTS + 6);
            sent += NPTS + 6;
        end
        while (sent < budget) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) len = $urandom_range(1, 8);
            else if (sel < 9) len = $urandom_range(9, 24);
            else len = $urandom_range(25, 48);
            send_run(len);
            sent += len;
        end
        wait_for_results();
    endtask

    task automatic test_register_access();
        apb_check(REG_CORR_FLOOR,  CORR_FLOOR_RST);
        apb_check(REG_SPREAD_FRAC, SPREAD_FRAC_RST);
        apb_check(REG_THR_FLOOR,   THR_FLOOR_RST);
        apply_settings(16'd32768, 16'hFFFF, 16'hFFFF);
        apply_settings(16'd0, 16'd0, 16'd0);
        apb_write(UNMAPPED_ADDR, $urandom);
        apply_settings(CORR_FLOOR_RST, SPREAD_FRAC_RST, THR_FLOOR_RST);
    endtask

    task automatic test_directed_points();
        send_point(16'd32768, 16'd0, 1'b1);
        send_point(16'd0, 16'hFFFF, 1'b1);
        send_point(CORR_FLOOR_RST, 16'd100, 1'b0);
        send_point(CORR_FLOOR_RST + 16'd1, 16'hFFFF, 1'b0);
        send_point(16'd32768, 16'd256, 1'b0);
        send_point(16'd16384, 16'd1000, 1'b0);
        send_point(16'd32768, 16'hFFFF, 1'b1);
        wait_for_results();
        // saturating ratios and a zero correlation with the floor at zero
        apply_settings(16'd0, 16'hFFFF, 16'd0);
        send_point(16'd1, 16'hFFFF, 1'b0);
        send_point(16'd255, 16'hFFFF, 1'b0);
        send_point(16'd256, 16'hFFFF, 1'b0);
        send_point(16'd0, 16'd5, 1'b0);
        send_point(16'd32768, 16'd1, 1'b1);
        wait_for_results();
        apply_settings(16'd32768, 16'd0, 16'hFFFF);
        send_point(16'd32768, 16'd100, 1'b0);
        send_point(16'd12345, 16'd4000, 1'b1);
        wait_for_results();
        // zero spread keeps only the smallest ratio
        apply_settings(16'd100, 16'd0, 16'd0);
        send_point(16'd20000, 16'd300, 1'b0);
        send_point(16'd20000, 16'd300, 1'b0);
        send_point(16'd30000, 16'd9000, 1'b0);
        send_point(16'd500, 16'd20, 1'b1);
        wait_for_results();
        apply_settings(CORR_FLOOR_RST, SPREAD_FRAC_RST, THR_FLOOR_RST);
    endtask

    task automatic test_full_store();
        logic [15:0] corr;
        logic [15:0] dev;
        corr = 16'($urandom_range(int'(cfg_corr_floor) + 1, 32768));
        dev  = pick_deviation();
        for (int i = 0; i < NPTS + 4; i++)
            send_point(corr, dev, i == NPTS + 3);
        wait_for_results();
    endtask

    task automatic test_backpressure();
        logic [15:0] corr;
        logic [15:0] dev;
        corr = 16'($urandom_range(int'(cfg_corr_floor) + 1, 32768));
        dev  = 16'($urandom_range(0, 65535));
        for (int i = 0; i < 12; i++)
            send_point(corr, dev, i == 11);
        hold_toggle <= ~hold_toggle;
        send_run(10);
        wait_for_results();
    endtask

    task automatic test_random_runs();
        random_runs(25, 1'b0);
        apply_settings(16'd0, 16'd0, 16'd0);
        random_runs(75, 1'b1);
        apply_settings(16'd32768, 16'hFFFF, 16'hFFFF);
        random_runs(10, 1'b0);
        apply_settings(16'($urandom_range(0, 32768)), 16'($urandom), 16'($urandom));
        random_runs(15, 1'b0);
        apply_settings(16'($urandom_range(0, 2000)), 16'hFFFF, 16'($urandom_range(0, 1024)));
        random_runs(15, 1'b0);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_access();
        test_directed_points();
        test_full_store();
        test_backpressure();
        test_random_runs();
        in_valid <= 1'b0;
        while (kept_queue.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        $display("covered %0d points in %0d runs, %0d result transfers, %0d register writes",
                 points_sent, runs_done, results_checked, reg_writes);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // receiver: changing ready patterns, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(16, 96);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_valid && out_ready) begin
            results_checked++;
            if (kept_queue.size() == 0) begin
                $error("unexpected result transfer: %p", out_data);
                fail_count++;
            end else begin
                want = kept_queue.pop_front();
                if (out_data.point_index !== want.point_index) begin
                    $error("point_index: expected %0d, got %0d",
                           want.point_index, out_data.point_index);
                    fail_count++;
                end
                if (out_data.kept_valid !== want.kept_valid) begin
                    $error("kept_valid: expected %0d, got %0d",
                           want.kept_valid, out_data.kept_valid);
                    fail_count++;
                end
                if (out_data.run_end !== want.run_end) begin
                    $error("run_end: expected %0d, got %0d", want.run_end, out_data.run_end);
                    fail_count++;
                end
                if (out_data.kept_total !== want.kept_total) begin
                    $error("kept_total: expected %0d, got %0d",
                           want.kept_total, out_data.kept_total);
                    fail_count++;
                end
                if (out_data.set_changed !== want.set_changed) begin
                    $error("set_changed: expected %0d, got %0d",
                           want.set_changed, out_data.set_changed);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: any transfer on any port restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ----- sim.f -----
hdl/tdof_pkg.sv
hdl/tiepoint_deviation_outlier_filter.sv
tb/tb_tiepoint_deviation_outlier_filter.sv
